// ===== rtl/wmrb_pkg.sv =====
// shared types and constants for the wireless mouse report builder
// no dependencies; imported by every module of the block
package wmrb_pkg;

  // payload button byte layout
  localparam int unsigned BtnResyncBit = 7;
  localparam int unsigned BtnSyncBit   = 6;
  localparam int unsigned BtnCount     = 3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMING_TARGET    = 8'd0,
    CFG_TIMING_TOLERANCE = 8'd1
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] TimingTargetRst    = 16'd7000;
  localparam logic [14:0] TimingToleranceRst = 15'd24;

  // configuration seen by the datapath
  typedef struct packed {
    logic [15:0] timing_target;
    logic [14:0] timing_tolerance;
  } cfg_t;

  // one received payload
  typedef struct packed {
    logic [7:0]         buttons;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [7:0]  wheel_pos;
    logic               last_in_frame;
    logic [15:0]        arrival_time;
    logic               report_pending;
  } item_t;

  // one built report
  typedef struct packed {
    logic               send_report;
    logic [BtnCount-1:0] report_buttons;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [7:0]  delta_wheel;
    logic               cancel_pending;
    logic               send_timing;
    logic signed [15:0] timing_offset;
  } result_t;

endpackage

// ===== rtl/wmrb_cfg_regs.sv =====
// timing configuration registers written over the config channel
// depends on wmrb_pkg
module wmrb_cfg_regs
  import wmrb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // always able to take a write
  assign cfg_ready_o = 1'b1;

  // register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timing_target    <= TimingTargetRst;
      cfg_q.timing_tolerance <= TimingToleranceRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TIMING_TARGET:    cfg_q.timing_target    <= cfg_data_i;
        CFG_TIMING_TOLERANCE: cfg_q.timing_tolerance <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/wmrb_input_reg.sv =====
// input register holding one payload ahead of the report datapath
// depends on wmrb_pkg
module wmrb_input_reg
  import wmrb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t in_item_i,
  input  logic  take_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // hold while the datapath cannot consume the stored payload
  assign in_stall_o = valid_q && !take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/wmrb_core.sv =====
// reference and button state, delta and timing logic, result register
// depends on wmrb_pkg
module wmrb_core
  import wmrb_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    take_o,
  output logic    res_valid_o,
  input  logic    res_stall_i,
  output result_t res_o
);

  logic                first_frame_q;
  logic [15:0]         ref_x_q, ref_y_q;
  logic [7:0]          ref_wheel_q;
  logic [BtnCount-1:0] accum_q, sent_q;
  logic                res_valid_q;
  result_t             res_q;

  logic                reload;
  logic [15:0]         ref_x_eff, ref_y_eff;
  logic [7:0]          ref_wheel_eff;
  logic [15:0]         dx, dy, off;
  logic [7:0]          dw;
  logic signed [16:0]  off_s, tol_s;
  logic                timing;
  logic [BtnCount-1:0] accum_d, sent_d;
  logic                send;
  logic                produce;
  result_t             res_d;

  // a non-last payload never blocks; a last one needs room in the result register
  assign take_o  = item_valid_i &&
                   (!item_i.last_in_frame || !res_valid_q || !res_stall_i);
  assign produce = take_o && item_i.last_in_frame;

  // reference reload during the first frame or on resync
  assign reload        = first_frame_q || item_i.buttons[BtnResyncBit];
  assign ref_x_eff     = reload ? item_i.pos_x     : ref_x_q;
  assign ref_y_eff     = reload ? item_i.pos_y     : ref_y_q;
  assign ref_wheel_eff = reload ? item_i.wheel_pos : ref_wheel_q;

  // wrapping deltas and timing offset
  always_comb begin
    dx     = item_i.pos_x - ref_x_eff;
    dy     = item_i.pos_y - ref_y_eff;
    dw     = item_i.wheel_pos - ref_wheel_eff;
    off    = item_i.arrival_time - cfg_i.timing_target;
    off_s  = {off[15], off};
    tol_s  = {2'b00, cfg_i.timing_tolerance};
    timing = item_i.buttons[BtnSyncBit] && ((off_s > tol_s) || (off_s < -tol_s));

    // cancel keeps the accumulated buttons, commit starts afresh
    sent_d  = item_i.report_pending ? sent_q : accum_q;
    accum_d = (item_i.report_pending ? accum_q : '0) | item_i.buttons[BtnCount-1:0];
    send    = (accum_d != sent_d) || (dx != '0) || (dy != '0) || (dw != '0);

    res_d.send_report    = send;
    res_d.report_buttons = accum_d;
    res_d.delta_x        = dx;
    res_d.delta_y        = dy;
    res_d.delta_wheel    = dw;
    res_d.cancel_pending = item_i.report_pending;
    res_d.send_timing    = timing;
    res_d.timing_offset  = off;
  end

  // block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_frame_q <= 1'b1;
      ref_x_q       <= '0;
      ref_y_q       <= '0;
      ref_wheel_q   <= '0;
      accum_q       <= '0;
      sent_q        <= '0;
    end else if (take_o) begin
      if (item_i.last_in_frame && !item_i.report_pending) begin
        ref_x_q     <= item_i.pos_x;
        ref_y_q     <= item_i.pos_y;
        ref_wheel_q <= item_i.wheel_pos;
      end else begin
        ref_x_q     <= ref_x_eff;
        ref_y_q     <= ref_y_eff;
        ref_wheel_q <= ref_wheel_eff;
      end
      if (item_i.last_in_frame) begin
        accum_q       <= accum_d;
        sent_q        <= sent_d;
        first_frame_q <= 1'b0;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (produce) begin
      res_valid_q <= 1'b1;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (produce) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/wireless_mouse_report_builder_unit.sv =====
// wireless mouse report builder: payload input register, report datapath, result register
// path: a last-in-frame payload passes the input register and then the result register
// throughput: one payload per cycle; input stalls only when the result register is held
// reset: asynchronous active low; references and buttons clear, first frame pending,
// timing target 7000 and tolerance 24
// depends on wmrb_pkg, wmrb_cfg_regs, wmrb_input_reg, wmrb_core
module wireless_mouse_report_builder_unit
  import wmrb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // payload channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          buttons_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [7:0]   wheel_pos_i,
  input  logic                last_in_frame_i,
  input  logic [15:0]         arrival_time_i,
  input  logic                report_pending_i,
  // report channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                send_report_o,
  output logic [2:0]          report_buttons_o,
  output logic signed [15:0]  delta_x_o,
  output logic signed [15:0]  delta_y_o,
  output logic signed [7:0]   delta_wheel_o,
  output logic                cancel_pending_o,
  output logic                send_timing_o,
  output logic signed [15:0]  timing_offset_o
);

  cfg_t    cfg;
  item_t   in_item, item;
  logic    item_valid, take;
  result_t res;

  wmrb_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // gather the payload ports
  always_comb begin
    in_item.buttons        = buttons_i;
    in_item.pos_x          = pos_x_i;
    in_item.pos_y          = pos_y_i;
    in_item.wheel_pos      = wheel_pos_i;
    in_item.last_in_frame  = last_in_frame_i;
    in_item.arrival_time   = arrival_time_i;
    in_item.report_pending = report_pending_i;
  end

  wmrb_input_reg u_in (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_item_i    (in_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wmrb_core u_core (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .res_valid_o  (out_valid_o),
    .res_stall_i  (out_stall_i),
    .res_o        (res)
  );

  // report fields
  assign send_report_o    = res.send_report;
  assign report_buttons_o = res.report_buttons;
  assign delta_x_o        = res.delta_x;
  assign delta_y_o        = res.delta_y;
  assign delta_wheel_o    = res.delta_wheel;
  assign cancel_pending_o = res.cancel_pending;
  assign send_timing_o    = res.send_timing;
  assign timing_offset_o  = res.timing_offset;

`ifndef SYNTHESIS
  // input only backs up behind a held report
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held report");

  // a report that is not sent carries no movement
  a_quiet_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !send_report_o) |->
      (delta_x_o == '0 && delta_y_o == '0 && delta_wheel_o == '0))
    else $error("movement present in a report that is not sent");

  // a held report stays valid, with its x delta and timing offset unchanged
  a_report_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(delta_x_o) && $stable(timing_offset_o)))
    else $error("held report changed");
`endif

endmodule

// ===== verif/testbench.sv =====
// testbench for wireless_mouse_report_builder_unit: directed rows, then phased random frames
// depends on wmrb_pkg and the rtl of the block; predicts every report and checks it field by field
`timescale 1ns / 1ps
module testbench;
  import wmrb_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PrintLimit    = 100;
  localparam int unsigned SettlePause   = 4;
  localparam int unsigned PhaseCount    = 5;
  localparam int unsigned PhaseItems    = 240;
  // register indexes the block has no register behind
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = 8'hFF;

  // one directed row: payload, and a typed report where it is obvious
  typedef struct packed {
    item_t   payload;
    logic    typed;
    result_t report;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [7:0] buttons_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic signed [7:0] wheel_pos_i;
  logic last_in_frame_i;
  logic [15:0] arrival_time_i;
  logic report_pending_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic send_report_o;
  logic [2:0] report_buttons_o;
  logic signed [15:0] delta_x_o;
  logic signed [15:0] delta_y_o;
  logic signed [7:0] delta_wheel_o;
  logic cancel_pending_o;
  logic send_timing_o;
  logic signed [15:0] timing_offset_o;

  item_t   payload = '0;
  logic    typed_row = 1'b0;
  result_t typed_report = '0;
  bit      idling_on = 1'b1;

  assign buttons_i        = payload.buttons;
  assign pos_x_i          = payload.pos_x;
  assign pos_y_i          = payload.pos_y;
  assign wheel_pos_i      = payload.wheel_pos;
  assign last_in_frame_i  = payload.last_in_frame;
  assign arrival_time_i   = payload.arrival_time;
  assign report_pending_i = payload.report_pending;

  wireless_mouse_report_builder_unit u_top (.*);

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state and its copy of the registers
  bit          first_pending = 1'b1;
  logic [15:0] anchor_x = '0;
  logic [15:0] anchor_y = '0;
  logic [7:0]  anchor_wheel = '0;
  logic [2:0]  held_buttons = '0;
  logic [2:0]  shown_buttons = '0;
  logic [15:0] target_setting = TimingTargetRst;
  logic [14:0] tolerance_setting = TimingToleranceRst;

  result_t awaited_reports[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PrintLimit) $display("[%0t] %s", $time, msg);
  endtask

  // reference reload, wrapping deltas, timing check and button commit for one payload
  function automatic bit predict_report(input item_t p, output result_t rep);
    logic [15:0] off;
    int          soff;
    int          tol;
    rep = '0;
    if (first_pending || p.buttons[BtnResyncBit]) begin
      anchor_x     = p.pos_x;
      anchor_y     = p.pos_y;
      anchor_wheel = p.wheel_pos;
    end
    if (!p.last_in_frame) return 1'b0;
    rep.delta_x     = p.pos_x - anchor_x;
    rep.delta_y     = p.pos_y - anchor_y;
    rep.delta_wheel = p.wheel_pos - anchor_wheel;
    off  = p.arrival_time - target_setting;
    soff = int'($signed(off));
    tol  = int'(tolerance_setting);
    rep.timing_offset  = off;
    rep.send_timing    = p.buttons[BtnSyncBit] && (soff > tol || soff < -tol);
    rep.cancel_pending = p.report_pending;
    // a pending report keeps the references and the accumulated buttons
    if (!p.report_pending) begin
      shown_buttons = held_buttons;
      held_buttons  = '0;
      anchor_x      = p.pos_x;
      anchor_y      = p.pos_y;
      anchor_wheel  = p.wheel_pos;
    end
    held_buttons       = held_buttons | p.buttons[BtnCount-1:0];
    rep.report_buttons = held_buttons;
    rep.send_report    = (held_buttons != shown_buttons) || rep.delta_x != 0 ||
                         rep.delta_y != 0 || rep.delta_wheel != 0;
    first_pending = 1'b0;
    return 1'b1;
  endfunction

  // transactions seen at the rising edge: check reports, predict, watchdog
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t predicted;
    bit      moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        got = '{send_report_o, report_buttons_o, delta_x_o, delta_y_o, delta_wheel_o,
                cancel_pending_o, send_timing_o, timing_offset_o};
        if (awaited_reports.size() == 0) begin
          report_mismatch($sformatf("report with none awaited: %h", got));
        end else begin
          want = awaited_reports.pop_front();
          if (got.send_report != want.send_report)
            report_mismatch($sformatf("send_report got %0d expected %0d",
                                      got.send_report, want.send_report));
          if (got.report_buttons != want.report_buttons)
            report_mismatch($sformatf("report_buttons got %0d expected %0d",
                                      got.report_buttons, want.report_buttons));
          if (got.delta_x != want.delta_x)
            report_mismatch($sformatf("delta_x got %0d expected %0d",
                                      got.delta_x, want.delta_x));
          if (got.delta_y != want.delta_y)
            report_mismatch($sformatf("delta_y got %0d expected %0d",
                                      got.delta_y, want.delta_y));
          if (got.delta_wheel != want.delta_wheel)
            report_mismatch($sformatf("delta_wheel got %0d expected %0d",
                                      got.delta_wheel, want.delta_wheel));
          if (got.cancel_pending != want.cancel_pending)
            report_mismatch($sformatf("cancel_pending got %0d expected %0d",
                                      got.cancel_pending, want.cancel_pending));
          if (got.send_timing != want.send_timing)
            report_mismatch($sformatf("send_timing got %0d expected %0d",
                                      got.send_timing, want.send_timing));
          if (got.timing_offset != want.timing_offset)
            report_mismatch($sformatf("timing_offset got %0d expected %0d",
                                      got.timing_offset, want.timing_offset));
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          CFG_TIMING_TARGET:    target_setting = cfg_data_i;
          CFG_TIMING_TOLERANCE: tolerance_setting = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        if (predict_report(payload, predicted))
          awaited_reports.push_back(typed_row ? typed_report : predicted);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver stalls in random bursts while idling is on
  always @(negedge clk_i) begin
    if (rst_ni && idling_on && !out_stall_i && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_index_i = idx;
    cfg_data_i  = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // offer one payload, with an optional gap first, and wait for its transaction
  task automatic send_item(item_t p, logic typed, result_t want);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    payload      = p;
    typed_row    = typed;
    typed_report = want;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // lets every awaited report arrive, then pauses for payloads with no report
  task automatic drain_reports();
    in_valid_i = 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk_i);
    repeat (SettlePause) @(negedge clk_i);
  endtask

  // directed rows under the reset timing target and tolerance
  stim_row_t directed_rows [16] = '{
    // first frame, not last: reload only
    '{'{8'h80, 16'sd100, -16'sd5, 8'sd3, 1'b0, 16'd7000, 1'b0}, 1'b0, '0},
    // first frame ends: references reload, deltas zero, buttons reported
    '{'{8'h47, 16'sd0, 16'sd0, 8'sd0, 1'b1, 16'd7000, 1'b0}, 1'b1,
      '{1'b1, 3'd7, 16'sd0, 16'sd0, 8'sd0, 1'b0, 1'b0, 16'sd0}},
    // extreme deltas; sync bit clear so no timing reply
    '{'{8'h00, 16'sd32767, 16'sh8000, 8'sd127, 1'b1, 16'd7025, 1'b0}, 1'b1,
      '{1'b1, 3'd0, 16'sd32767, 16'sh8000, 8'sd127, 1'b0, 1'b0, 16'sd25}},
    // just past tolerance, nothing changed: fields still carried
    '{'{8'h40, 16'sd32767, 16'sh8000, 8'sd127, 1'b1, 16'd7025, 1'b0}, 1'b1,
      '{1'b0, 3'd0, 16'sd0, 16'sd0, 8'sd0, 1'b0, 1'b1, 16'sd25}},
    // exactly at minus tolerance
    '{'{8'h40, 16'sd32767, 16'sh8000, 8'sd127, 1'b1, 16'd6976, 1'b0}, 1'b1,
      '{1'b0, 3'd0, 16'sd0, 16'sd0, 8'sd0, 1'b0, 1'b0, -16'sd24}},
    '{'{8'h40, 16'sd32767, 16'sh8000, 8'sd127, 1'b1, 16'd6975, 1'b0}, 1'b1,
      '{1'b0, 3'd0, 16'sd0, 16'sd0, 8'sd0, 1'b0, 1'b1, -16'sd25}},
    // pending report cancelled twice, buttons accumulate, then committed
    '{'{8'h01, 16'sd0, 16'sd0, 8'sd0, 1'b1, 16'd7000, 1'b1}, 1'b0, '0},
    '{'{8'h02, 16'sd5, 16'sd5, 8'sd5, 1'b1, 16'd7000, 1'b1}, 1'b0, '0},
    '{'{8'h04, 16'sd5, 16'sd5, 8'sd5, 1'b1, 16'd7000, 1'b0}, 1'b0, '0},
    // resync mid frame, then a plain payload whose buttons are dropped
    '{'{8'h80, 16'sd1000, 16'sd1000, 8'sh80, 1'b0, 16'd7000, 1'b0}, 1'b0, '0},
    '{'{8'h07, 16'sd2000, 16'sd2000, 8'sd50, 1'b0, 16'd7000, 1'b0}, 1'b0, '0},
    '{'{8'h00, 16'sd1000, 16'sd1000, 8'sh80, 1'b1, 16'd7000, 1'b0}, 1'b0, '0},
    // resync on the last payload, arrival far early
    '{'{8'hC0, -16'sd1, -16'sd1, -8'sd1, 1'b1, 16'd0, 1'b0}, 1'b0, '0},
    // every button bit, latest arrival, pending
    '{'{8'hFF, 16'sh8000, 16'sd32767, 8'sh80, 1'b1, 16'hFFFF, 1'b1}, 1'b0, '0},
    // unused button bits only
    '{'{8'h38, 16'sh8000, 16'sd32767, 8'sh80, 1'b1, 16'd7024, 1'b0}, 1'b0, '0},
    '{'{8'h00, 16'sh8000, 16'sd32767, 8'sh80, 1'b1, 16'd7000, 1'b0}, 1'b0, '0}
  };

  // reset, directed rows, random phases, final check
  initial begin
    item_t       p;
    logic [15:0] mouse_x;
    logic [15:0] mouse_y;
    logic [7:0]  mouse_w;
    int          off;
    mouse_x = '0;
    mouse_y = '0;
    mouse_w = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].payload, directed_rows[i].typed, directed_rows[i].report);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain_reports();
      case (ph)
        0: begin
          write_register(CFG_TIMING_TARGET, 16'h0000);
          write_register(CFG_TIMING_TOLERANCE, 16'h0000);
        end
        1: begin
          // tolerance keeps only its low 15 bits
          write_register(CFG_TIMING_TARGET, 16'hFFFF);
          write_register(CFG_TIMING_TOLERANCE, 16'hFFFF);
        end
        2: begin
          write_register(CFG_TIMING_TARGET, 16'($urandom));
          write_register(CFG_TIMING_TOLERANCE, 16'($urandom_range(0, 300)));
          write_register(CfgIdxSpare, 16'($urandom));
          write_register(CfgIdxTop, 16'($urandom));
        end
        3: begin
          write_register(CFG_TIMING_TARGET, 16'h8000);
          write_register(CFG_TIMING_TOLERANCE, 16'h0001);
        end
        default: begin
          write_register(CFG_TIMING_TARGET, TimingTargetRst);
          write_register(CFG_TIMING_TOLERANCE, 16'(TimingToleranceRst));
        end
      endcase

      for (int k = 0; k < PhaseItems; k++) begin
        // stretches with and without idling; none in the last phase
        if (k % 40 == 0) idling_on = (ph != PhaseCount - 1) && ($urandom_range(0, 9) < 7);
        if ($urandom_range(0, 99) < 15) begin
          // noise: every field random
          p = {$urandom, $urandom, 2'($urandom)};
          p.buttons = 8'($urandom);
        end else begin
          // well-formed payload: counters move on, arrival close to the target
          if ($urandom_range(0, 9) == 0) begin
            mouse_x = 16'($urandom);
            mouse_y = 16'($urandom);
            mouse_w = 8'($urandom);
          end else begin
            mouse_x = mouse_x + 16'($urandom_range(0, 40) - 20);
            mouse_y = mouse_y + 16'($urandom_range(0, 40) - 20);
            mouse_w = mouse_w + 8'($urandom_range(0, 6) - 3);
          end
          p.pos_x     = mouse_x;
          p.pos_y     = mouse_y;
          p.wheel_pos = mouse_w;
          p.buttons   = 8'($urandom);
          p.buttons[BtnResyncBit] = ($urandom_range(0, 19) == 0);
          p.last_in_frame  = ($urandom_range(0, 99) < 45);
          p.report_pending = ($urandom_range(0, 3) == 0);
          off = int'($urandom_range(0, 2 * tolerance_setting + 6)) -
                int'(tolerance_setting) - 3;
          p.arrival_time = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                           target_setting + 16'(off);
        end
        send_item(p, 1'b0, '0);
      end
    end

    drain_reports();
    repeat (SettlePause) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
